// File: sv/pd_path_follower_top_defines.svh
// Assertion macros shared by the path follower RTL.
`ifndef PD_PATH_FOLLOWER_TOP_DEFINES_SVH
`define PD_PATH_FOLLOWER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define PDPF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pd_path_follower: assertion failed");
`define PDPF_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("pd_path_follower: forbidden condition");
`else
`define PDPF_ASSERT(lbl, clk, rst_n, prop)
`define PDPF_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: sv/pdpf_pkg.sv
// Shared types, codes and constants of the path follower.
package pdpf_pkg;

	localparam int PATH_DEPTH_DEF = 1024;
	localparam int EL_W           = 20;
	localparam int NUM_W          = 57;
	localparam int N_W            = 77;
	localparam int MA_W           = 34;
	localparam int MB_W           = 25;
	localparam int P_W            = 59;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 31;
	localparam int TGT_W          = 10;
	localparam int MUL_STEPS      = 16;

	localparam logic [EL_W-1:0] ONE_MILLION = 20'd1000000;

	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIN_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ANG_LIMIT  = 3'd4;

	localparam logic [3:0] OP_NOP = 4'd0;
	localparam logic [3:0] OP_WW  = 4'd1;
	localparam logic [3:0] OP_ZZ  = 4'd2;
	localparam logic [3:0] OP_ZW  = 4'd3;
	localparam logic [3:0] OP_CDX = 4'd4;
	localparam logic [3:0] OP_SDY = 4'd5;
	localparam logic [3:0] OP_CDY = 4'd6;
	localparam logic [3:0] OP_SDX = 4'd7;
	localparam logic [3:0] OP_PF  = 4'd8;
	localparam logic [3:0] OP_DF  = 4'd9;
	localparam logic [3:0] OP_PL  = 4'd10;
	localparam logic [3:0] OP_DL  = 4'd11;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic               first_point;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic [19:0]        elapsed_us;
	} in_t;

	typedef struct packed {
		logic signed [31:0] linear_cmd;
		logic signed [31:0] angular_cmd;
		logic [TGT_W-1:0]   target_index;
		logic               path_empty;
	} out_t;

	typedef struct packed {
		logic       store;
		logic       load_in;
		logic       search_start;
		logic       cap_delta;
		logic [3:0] op;
		logic       axis;
		logic       div_start;
		logic       cap_lin;
		logic       cap_ang;
		logic       load_out;
		logic       empty;
	} cmd_t;

	typedef struct packed {
		logic path_empty;
		logic search_done;
		logic div_done;
	} sts_t;

	// Multiplier schedule; gaps let products land before their users read them.
	function automatic logic [3:0] mul_sched(input logic [3:0] step);
		logic [3:0] op;
		unique case (step)
			4'd0:    op = OP_WW;
			4'd1:    op = OP_ZZ;
			4'd2:    op = OP_ZW;
			4'd4:    op = OP_CDX;
			4'd5:    op = OP_SDY;
			4'd6:    op = OP_CDY;
			4'd7:    op = OP_SDX;
			4'd11:   op = OP_PF;
			4'd12:   op = OP_DF;
			4'd13:   op = OP_PL;
			4'd14:   op = OP_DL;
			default: op = OP_NOP;
		endcase
		return op;
	endfunction

endpackage

// File: sv/pdpf_div.sv
// Restoring divider, one quotient bit per cycle.
module pdpf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pdpf_pkg::N_W-1:0]  dividend,
	input  logic [pdpf_pkg::EL_W-1:0] divisor,
	output logic                      done,
	output logic [pdpf_pkg::N_W-1:0]  quotient
);
	localparam int NW = pdpf_pkg::N_W;
	localparam int DW = pdpf_pkg::EL_W;
	localparam int CNT_W = $clog2(NW);

	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      sh;
	logic             ge;
	logic [DW:0]      diff;

	assign sh   = {rem_q, quo_q[NW-1]};
	assign ge   = sh >= {1'b0, dsr_q};
	assign diff = sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: sv/pdpf_ctrl.sv
// Sequencer for point storage, target search, arithmetic and result hand-off.
module pdpf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_kind,
	output logic             out_valid,
	input  logic             out_ready,
	input  pdpf_pkg::sts_t   sts,
	output pdpf_pkg::cmd_t   cmd
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SEARCH = 4'd1;
	localparam logic [3:0] S_FETCH  = 4'd2;
	localparam logic [3:0] S_DELTA  = 4'd3;
	localparam logic [3:0] S_MUL    = 4'd4;
	localparam logic [3:0] S_DIVF   = 4'd5;
	localparam logic [3:0] S_DIVFW  = 4'd6;
	localparam logic [3:0] S_DIVLP  = 4'd7;
	localparam logic [3:0] S_DIVL   = 4'd8;
	localparam logic [3:0] S_DIVLW  = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	logic [3:0] state_q, state_n;
	logic [3:0] step_q;
	logic       empty_q;
	logic       out_valid_q;
	logic       load;

	always_comb begin
		cmd      = '0;
		state_n  = state_q;
		in_ready = 1'b0;
		load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (!in_kind) begin
						cmd.store = 1'b1;
					end else if (sts.path_empty) begin
						state_n = S_OUT;
					end else begin
						cmd.search_start = 1'b1;
						state_n = S_SEARCH;
					end
				end
			end
			S_SEARCH: if (sts.search_done) state_n = S_FETCH;
			S_FETCH:  state_n = S_DELTA;
			S_DELTA: begin
				cmd.cap_delta = 1'b1;
				state_n = S_MUL;
			end
			S_MUL: begin
				cmd.op = pdpf_pkg::mul_sched(step_q);
				if (step_q == 4'(pdpf_pkg::MUL_STEPS - 1)) state_n = S_DIVF;
			end
			S_DIVF: begin
				cmd.div_start = 1'b1;
				state_n = S_DIVFW;
			end
			S_DIVFW: begin
				if (sts.div_done) begin
					cmd.cap_lin = 1'b1;
					state_n = S_DIVLP;
				end
			end
			S_DIVLP: begin
				cmd.axis = 1'b1;
				state_n = S_DIVL;
			end
			S_DIVL: begin
				cmd.axis = 1'b1;
				cmd.div_start = 1'b1;
				state_n = S_DIVLW;
			end
			S_DIVLW: begin
				cmd.axis = 1'b1;
				if (sts.div_done) begin
					cmd.cap_ang = 1'b1;
					state_n = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					load = 1'b1;
					cmd.load_out = 1'b1;
					cmd.empty = empty_q;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_MUL) step_q <= step_q + 4'd1;
			else step_q <= '0;
			if (state_q == S_IDLE && in_valid) empty_q <= in_kind && sts.path_empty;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

// File: sv/pdpf_dp.sv
// Datapath: path store, target search pipeline, shared multiplier, PD math.
module pdpf_dp #(
	parameter int PATH_DEPTH = pdpf_pkg::PATH_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pdpf_pkg::in_t                   in_item,
	input  logic                            cfg_we,
	input  logic [pdpf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdpf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  pdpf_pkg::cmd_t                  cmd,
	output pdpf_pkg::sts_t                  sts,
	output pdpf_pkg::out_t                  out_item
);
	localparam int AW  = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
	localparam int CW  = $clog2(PATH_DEPTH + 1);
	localparam int PW  = pdpf_pkg::P_W;
	localparam int NMW = pdpf_pkg::NUM_W;
	localparam int NW  = pdpf_pkg::N_W;
	localparam int TW  = pdpf_pkg::TGT_W;

	localparam logic signed [PW:0] S_MAX = (PW + 1)'(2147483647);
	localparam logic signed [PW:0] S_MIN = -S_MAX - (PW + 1)'(1);

	function automatic logic signed [31:0] sat32(input logic signed [PW:0] v);
		logic signed [31:0] r;
		if (v > S_MAX) r = 32'sh7fffffff;
		else if (v < S_MIN) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] clamp(input logic signed [63:0] u,
		input logic [30:0] lim);
		logic signed [63:0] l;
		logic signed [63:0] r;
		l = $signed({33'b0, lim});
		if (u > l) r = l;
		else if (u < -l) r = -l;
		else r = u;
		return r[31:0];
	endfunction

	// configuration
	logic [23:0] pg_q, dg_q;
	logic [30:0] d_q, llim_q, alim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_q   <= 24'd131072;
			dg_q   <= 24'd6554;
			d_q    <= 31'd13107;
			llim_q <= 31'd19661;
			alim_q <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdpf_pkg::CFG_PROP_GAIN:  pg_q   <= cfg_data[23:0];
				pdpf_pkg::CFG_DERIV_GAIN: dg_q   <= cfg_data[23:0];
				pdpf_pkg::CFG_LOOKAHEAD:  d_q    <= cfg_data;
				pdpf_pkg::CFG_LIN_LIMIT:  llim_q <= cfg_data;
				pdpf_pkg::CFG_ANG_LIMIT:  alim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// path store
	logic [63:0]   mem [PATH_DEPTH];
	logic [63:0]   rd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] base;
	logic [CW-1:0] cm1;
	logic          wr_ok;
	logic [AW-1:0] idx_q, target_q, rd_addr;
	logic          issuing_q;

	assign base  = in_item.first_point ? '0 : count_q;
	assign wr_ok = cmd.store && (base < CW'(PATH_DEPTH));
	assign cm1   = count_q - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (wr_ok) count_q <= base + CW'(1);
	end

	always_ff @(posedge clk) begin
		if (wr_ok) mem[base[AW-1:0]] <= {in_item.pos_x, in_item.pos_y};
		rd_q <= mem[rd_addr];
	end

	assign rd_addr = issuing_q ? idx_q : target_q;

	// latched pose
	logic signed [31:0] px_q, py_q;
	logic signed [15:0] z_q, w_q;
	logic [19:0]        el_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q <= in_item.pos_x;
			py_q <= in_item.pos_y;
			z_q  <= in_item.quat_z;
			w_q  <= in_item.quat_w;
			el_q <= (in_item.elapsed_us == '0) ? 20'd1 : in_item.elapsed_us;
		end
	end

	// search pipeline
	logic signed [32:0] ex, ey, d33, ax, ay;
	logic               inbox;
	logic               v_s1, v_s2, v_s3;
	logic               last_s1, last_s2, last_s3;
	logic [AW-1:0]      tag_s1, tag_s2, tag_s3;
	logic               inbox_s2, inbox_s3;
	logic [30:0]        ax_s2, ay_s2;
	logic [61:0]        sqx_s3, sqy_s3, d2_q;
	logic               hit, done;

	assign ex    = $signed({rd_q[63], rd_q[63:32]}) - $signed({px_q[31], px_q});
	assign ey    = $signed({rd_q[31], rd_q[31:0]}) - $signed({py_q[31], py_q});
	assign d33   = $signed({2'b0, d_q});
	assign inbox = (ex <= d33) && (ex >= -d33) && (ey <= d33) && (ey >= -d33);
	assign ax    = ex[32] ? -ex : ex;
	assign ay    = ey[32] ? -ey : ey;
	assign hit   = v_s3 && inbox_s3 && ({1'b0, sqx_s3} + {1'b0, sqy_s3} <= {1'b0, d2_q});
	assign done  = v_s3 && (hit || last_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (done) begin
			issuing_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (cmd.search_start) issuing_q <= 1'b1;
			else if (issuing_q && idx_q == '0) issuing_q <= 1'b0;
			v_s1 <= issuing_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search_start) idx_q <= cm1[AW-1:0];
		else if (issuing_q && idx_q != '0) idx_q <= idx_q - AW'(1);
		if (done) target_q <= hit ? tag_s3 : '0;
		tag_s1   <= idx_q;
		last_s1  <= (idx_q == '0);
		tag_s2   <= tag_s1;
		last_s2  <= last_s1;
		inbox_s2 <= inbox;
		ax_s2    <= ax[30:0];
		ay_s2    <= ay[30:0];
		tag_s3   <= tag_s2;
		last_s3  <= last_s2;
		inbox_s3 <= inbox_s2;
		sqx_s3   <= {31'b0, ax_s2} * {31'b0, ax_s2};
		sqy_s3   <= {31'b0, ay_s2} * {31'b0, ay_s2};
		d2_q     <= {31'b0, d_q} * {31'b0, d_q};
	end

	// shared multiplier
	logic signed [32:0]                dx_q, dy_q;
	logic signed [31:0]                ww_q, zz_q, zw_q;
	logic signed [32:0]                cdiff;
	logic signed [17:0]                c18, s18;
	logic signed [pdpf_pkg::MA_W-1:0]  mul_a;
	logic signed [pdpf_pkg::MB_W-1:0]  mul_b;
	logic signed [PW-1:0]              prod_q;
	logic [3:0]                        op_s1;
	logic signed [PW-1:0]              cdx_q, sdy_q, cdy_q, sdx_q, pf_q, pl_q;
	logic [NMW-1:0]                    nf_q, nl_q;
	logic signed [31:0]                fwd_q, lat_q, prev_f_q, prev_l_q;
	logic signed [32:0]                df, dl;
	logic [32:0]                       magf_q, magl_q;
	logic                              negf_q, negl_q;
	logic signed [PW:0]                fsum, lsum;

	assign cdiff = $signed({ww_q[31], ww_q}) - $signed({zz_q[31], zz_q});
	assign c18   = cdiff[32:15];
	assign s18   = zw_q[31:14];

	always_comb begin
		unique case (cmd.op)
			pdpf_pkg::OP_WW:  begin mul_a = 34'(w_q);  mul_b = 25'(w_q); end
			pdpf_pkg::OP_ZZ:  begin mul_a = 34'(z_q);  mul_b = 25'(z_q); end
			pdpf_pkg::OP_ZW:  begin mul_a = 34'(z_q);  mul_b = 25'(w_q); end
			pdpf_pkg::OP_CDX: begin mul_a = 34'(dx_q); mul_b = 25'(c18); end
			pdpf_pkg::OP_SDY: begin mul_a = 34'(dy_q); mul_b = 25'(s18); end
			pdpf_pkg::OP_CDY: begin mul_a = 34'(dy_q); mul_b = 25'(c18); end
			pdpf_pkg::OP_SDX: begin mul_a = 34'(dx_q); mul_b = 25'(s18); end
			pdpf_pkg::OP_PF: begin
				mul_a = 34'(fwd_q);
				mul_b = $signed({1'b0, pg_q});
			end
			pdpf_pkg::OP_DF: begin
				mul_a = $signed({1'b0, magf_q});
				mul_b = $signed({1'b0, dg_q});
			end
			pdpf_pkg::OP_PL: begin
				mul_a = 34'(lat_q);
				mul_b = $signed({1'b0, pg_q});
			end
			pdpf_pkg::OP_DL: begin
				mul_a = $signed({1'b0, magl_q});
				mul_b = $signed({1'b0, dg_q});
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign fsum = ($signed({cdx_q[PW-1], cdx_q}) + $signed({sdy_q[PW-1], sdy_q})) >>> 15;
	assign lsum = ($signed({cdy_q[PW-1], cdy_q}) - $signed({sdx_q[PW-1], sdx_q})) >>> 15;
	assign df   = $signed({fwd_q[31], fwd_q}) - $signed({prev_f_q[31], prev_f_q});
	assign dl   = $signed({lat_q[31], lat_q}) - $signed({prev_l_q[31], prev_l_q});

	always_ff @(posedge clk) begin
		if (cmd.cap_delta) begin
			dx_q <= ex;
			dy_q <= ey;
		end
		prod_q <= PW'(mul_a * mul_b);
		op_s1  <= cmd.op;
		unique case (op_s1)
			pdpf_pkg::OP_WW:  ww_q  <= prod_q[31:0];
			pdpf_pkg::OP_ZZ:  zz_q  <= prod_q[31:0];
			pdpf_pkg::OP_ZW:  zw_q  <= prod_q[31:0];
			pdpf_pkg::OP_CDX: cdx_q <= prod_q;
			pdpf_pkg::OP_SDY: sdy_q <= prod_q;
			pdpf_pkg::OP_CDY: cdy_q <= prod_q;
			pdpf_pkg::OP_SDX: sdx_q <= prod_q;
			pdpf_pkg::OP_PF:  pf_q  <= prod_q;
			pdpf_pkg::OP_DF:  nf_q  <= prod_q[NMW-1:0];
			pdpf_pkg::OP_PL:  pl_q  <= prod_q;
			pdpf_pkg::OP_DL:  nl_q  <= prod_q[NMW-1:0];
			default: ;
		endcase
		fwd_q  <= sat32(fsum);
		lat_q  <= sat32(lsum);
		negf_q <= df[32];
		magf_q <= df[32] ? $unsigned(-df) : $unsigned(df);
		negl_q <= dl[32];
		magl_q <= dl[32] ? $unsigned(-dl) : $unsigned(dl);
	end

	// derivative term: floor(num * 1e6 / elapsed) >> 16
	logic [NW-1:0]      n_q;
	logic               div_done;
	logic [NW-1:0]      quo;
	logic [63:0]        t64;
	logic signed [63:0] pf64, pl64, ul, ua;
	logic signed [31:0] lc_q, ac_q;

	always_ff @(posedge clk) begin
		n_q <= NW'(cmd.axis ? nl_q : nf_q) * NW'(pdpf_pkg::ONE_MILLION);
	end

	pdpf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (n_q),
		.divisor  (el_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign t64  = {3'b0, quo[NW-1:16]};
	assign pf64 = 64'(pf_q >>> 16);
	assign pl64 = 64'(pl_q >>> 16);
	assign ul   = pf64 + (negf_q ? -$signed(t64) : $signed(t64));
	assign ua   = pl64 + (negl_q ? -$signed(t64) : $signed(t64));

	logic [AW+TW-1:0] tgt_wide;
	assign tgt_wide = {{TW{1'b0}}, target_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_f_q <= '0;
			prev_l_q <= '0;
		end else if (cmd.load_out && !cmd.empty) begin
			prev_f_q <= fwd_q;
			prev_l_q <= lat_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_lin) lc_q <= clamp(ul, llim_q);
		if (cmd.cap_ang) ac_q <= clamp(ua, alim_q);
		if (cmd.load_out) begin
			if (cmd.empty) begin
				out_item <= '{linear_cmd: '0, angular_cmd: '0, target_index: '0,
					path_empty: 1'b1};
			end else begin
				out_item <= '{linear_cmd: lc_q, angular_cmd: ac_q,
					target_index: tgt_wide[TW-1:0], path_empty: 1'b0};
			end
		end
	end

	assign sts.path_empty  = (count_q == '0);
	assign sts.search_done = done;
	assign sts.div_done    = div_done;
endmodule

// File: sv/pd_path_follower_top.sv
// Top level of the PD lookahead path follower.
//
// Input requests carry either a path point (kind 0) or a robot pose (kind 1).
// A path point is written into the path store in the cycle it is accepted and
// yields no result; first_point restarts the path, points past the store
// depth are dropped. A pose request runs one control step and yields exactly
// one result request with the clamped linear and angular commands.
// A pose runs the search pipeline, which reads one stored point per cycle
// through the store's single read port, then the shared 34x25 multiplier
// and two passes through the bit-serial divider. An empty path skips these
// and goes straight to the hand-off, where its result marks path_empty.
// The block takes one request at a time; in_ready is high only when idle.
// The result register holds a finished result while the receiver stalls, so
// new path points are still taken; a pose then waits before its hand-off.
// Configuration writes must be made only while idle; the block does not enforce
// it. Reset clears the path count, the previous errors and the output valid
// and loads the register defaults; the store contents are not cleared.
`include "pd_path_follower_top_defines.svh"
module pd_path_follower_top #(
	parameter int PATH_DEPTH = pdpf_pkg::PATH_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  pdpf_pkg::in_t                   in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output pdpf_pkg::out_t                  out_item,
	input  logic                            cfg_we,
	input  logic [pdpf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdpf_pkg::CFG_DATA_W-1:0] cfg_data
);
	pdpf_pkg::cmd_t cmd;
	pdpf_pkg::sts_t sts;

	// sequencer: owns the handshakes and steps the datapath
	pdpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_kind   (in_item.kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: store, search, multiply, divide, clamp, result register
	pdpf_dp #(
		.PATH_DEPTH (PATH_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_item  (out_item)
	);

	// a pose against an empty path must leave idle for the hand-off state
	`PDPF_ASSERT(a_empty_pose_busy, clk, arst_n, in_valid && in_ready && in_item.kind && sts.path_empty |=> !in_ready)
	// loading the result register always raises out_valid
	`PDPF_ASSERT(a_load_sets_valid, clk, arst_n, cmd.load_out |=> out_valid)
	// the divider is never started while the block is idle
	`PDPF_NEVER(a_no_div_idle, clk, arst_n, in_ready && cmd.div_start)
endmodule
